// ===== rtl/isr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the insertion_sort_range block.
// No dependencies.
package isr_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned RANGE_W = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LAST  = 2'd1;

  localparam logic [RANGE_W-1:0] RANGE_FIRST_RST = 6'd0;
  localparam logic [RANGE_W-1:0] RANGE_LAST_RST  = 6'd63;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } isr_state_t;

  typedef struct packed {
    logic               load_en;
    logic [CNT_W-1:0]   wr_idx;
    logic               sorting;
    logic               phase;
    logic               shift;
    logic [RANGE_W-1:0] first;
    logic [RANGE_W-1:0] last;
  } cell_ctrl_t;

endpackage

// ===== rtl/isr_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorting chain: holds one element, loads, compare-exchanges
// with its right neighbour and shifts towards cell 0. Depends on isr_pkg.
module isr_cell
  import isr_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic                     left_swap,
  input  logic signed [DATA_W-1:0] right_val,
  output logic signed [DATA_W-1:0] val,
  output logic                     swap_right
);

  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

  logic active;

  assign active = ctrl.sorting && (IDX[0] == ctrl.phase) &&
                  (IDX >= {1'b0, ctrl.first}) && (IDX1 <= {1'b0, ctrl.last});

  // strict compare keeps equal values in order
  assign swap_right = active && (val > right_val);

  always_ff @(posedge clk) begin
    if (ctrl.load_en && ctrl.wr_idx == IDX) begin
      val <= sample_value;
    end else if (ctrl.shift || swap_right) begin
      val <= right_val;
    end else if (left_swap) begin
      val <= left_val;
    end
  end

endmodule

// ===== rtl/isr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the sorting chain: load count, transposition passes, emission.
// Depends on isr_pkg.
module isr_ctrl
  import isr_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               final_item,
  input  logic [RANGE_W-1:0] range_first,
  input  logic [RANGE_W-1:0] range_last,
  output logic               busy,
  output cell_ctrl_t         ctrl,
  output logic               result_valid,
  output logic               final_result
);

  localparam logic [CNT_W-1:0]   DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [RANGE_W-1:0] PASS_LAST = RANGE_W'(DEPTH - 1);

  isr_state_t         state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [RANGE_W-1:0] pass, pass_next;
  logic               accept, room, window_ok;
  logic [CNT_W-1:0]   count_new;

  assign accept    = start && (state == ST_LOAD);
  assign room      = count < DEPTH_C;
  assign count_new = room ? count + CNT_W'(1) : count;
  assign window_ok = (count_new >= CNT_W'(2)) && ({1'b0, range_last} < count_new) &&
                     (range_first <= range_last);

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && final_item) begin
          state_next = window_ok ? ST_SORT : ST_EMIT;
        end
      end
      ST_SORT: begin
        if (pass == PASS_LAST) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (count == CNT_W'(1)) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    count_next = count;
    pass_next  = '0;
    case (state)
      ST_LOAD: begin
        if (accept) begin
          count_next = count_new;
        end
      end
      ST_SORT: begin
        pass_next = pass + RANGE_W'(1);
      end
      ST_EMIT: begin
        count_next = count - CNT_W'(1);
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  always_comb begin
    busy         = (state != ST_LOAD);
    ctrl.load_en = accept && room;
    ctrl.wr_idx  = count;
    ctrl.sorting = (state == ST_SORT);
    ctrl.phase   = pass[0];
    ctrl.shift   = (state == ST_EMIT);
    ctrl.first   = range_first;
    ctrl.last    = range_last;
    result_valid = (state == ST_EMIT);
    final_result = (state == ST_EMIT) && (count == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      pass  <= pass_next;
    end
  end

endmodule

// ===== rtl/insertion_sort_range.sv =====
`timescale 1ns / 1ps
// Block sorter: one value per cycle while loading (busy low). After the final
// beat, compare-exchange passes run when the window applies, then one result
// per cycle for the n held values; busy stays high until the last result.
// Reset clears the sequencer and sets range_first 0, range_last 63; held data is
// undefined. The receiver cannot stall the result beats.
module insertion_sort_range
  import isr_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic                     final_item,
  output logic                     result_valid,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     final_result,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [RANGE_W-1:0]       cfg_data
);

  logic [RANGE_W-1:0] range_first, range_last;
  cell_ctrl_t         ctrl;

  logic signed [DATA_W-1:0] vals  [DEPTH];
  logic                     swaps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_first <= RANGE_FIRST_RST;
      range_last  <= RANGE_LAST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_FIRST: range_first <= cfg_data;
        REG_RANGE_LAST:  range_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  isr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .final_item   (final_item),
    .range_first  (range_first),
    .range_last   (range_last),
    .busy         (busy),
    .ctrl         (ctrl),
    .result_valid (result_valid),
    .final_result (final_result)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lv, rv;
    logic                     ls;
    if (i == 0) begin : g_head
      assign lv = '0;
      assign ls = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign ls = swaps[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = vals[i];
    end else begin : g_body
      assign rv = vals[i+1];
    end
    isr_cell #(
      .INDEX(i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .sample_value (sample_value),
      .left_val     (lv),
      .left_swap    (ls),
      .right_val    (rv),
      .val          (vals[i]),
      .swap_right   (swaps[i])
    );
  end

  assign sorted_value = vals[0];

endmodule

// ===== dv/tb_insertion_sort_range.sv =====
`timescale 1ns / 1ps
// Self-checking bench for insertion_sort_range: random bursts of sample beats, a window
// predictor that checks every result beat, and window register changes between blocks.
// Depends on isr_pkg and the insertion_sort_range RTL.
module tb_insertion_sort_range;
  import isr_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SAMPLE_TARGET = 420;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } beat_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] sample_value;
  logic                     final_item;
  logic                     result_valid;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_result;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [RANGE_W-1:0]       cfg_data;

  beat_t sample_queue[$];
  beat_t pending_results[$];
  beat_t drv_beat;
  beat_t exp_beat;

  logic signed [DATA_W-1:0] held_values[DEPTH];
  int unsigned held_count;
  int unsigned win_first;
  int unsigned win_last;

  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned errors = 0;
  int unsigned samples_queued;
  int unsigned blocks_done = 0;
  int unsigned results_checked = 0;

  insertion_sort_range #(.DEPTH(DEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_value (sample_value),
    .final_item   (final_item),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .final_result (final_result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stable in-window insertion sort of the held block, then queue the whole block.
  task automatic take_sample(input logic signed [DATA_W-1:0] value, input logic last);
    beat_t res;
    logic signed [DATA_W-1:0] tmp;
    int unsigned n;
    int unsigned j;
    if (held_count < DEPTH) begin
      held_values[held_count] = value;
      held_count++;
    end
    if (last) begin
      n = held_count;
      if (n >= 2 && win_last < n && win_first <= win_last) begin
        for (int unsigned i = win_first + 1; i <= win_last; i++) begin
          j = i;
          while (j > win_first && held_values[j-1] > held_values[j]) begin
            tmp = held_values[j-1];
            held_values[j-1] = held_values[j];
            held_values[j] = tmp;
            j--;
          end
        end
      end
      for (int unsigned k = 0; k < n; k++) begin
        res.value = held_values[k];
        res.last = (k + 1 == n);
        pending_results.push_back(res);
      end
      held_count = 0;
      blocks_done++;
    end
  endtask

  // Driver: bursts of random length with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      sample_value <= '0;
      final_item <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!start || !busy) begin
      if (gap_left != 0 || sample_queue.size() == 0) begin
        start <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        drv_beat = sample_queue.pop_front();
        start <= 1'b1;
        sample_value <= drv_beat.value;
        final_item <= drv_beat.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: register writes, accepted samples, and result beats.
  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      win_first = int'(RANGE_FIRST_RST);
      win_last = int'(RANGE_LAST_RST);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RANGE_FIRST: win_first = int'(cfg_data);
          REG_RANGE_LAST:  win_last = int'(cfg_data);
          default: ;
        endcase
      end
      if (start && !busy) take_sample(sample_value, final_item);
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: sorted_value %0d final_result %0b",
                 sorted_value, final_result);
          errors++;
        end else begin
          exp_beat = pending_results.pop_front();
          if (sorted_value !== exp_beat.value) begin
            $error("sorted_value: expected %0d, got %0d", exp_beat.value, sorted_value);
            errors++;
          end
          if (final_result !== exp_beat.last) begin
            $error("final_result: expected %0b, got %0b", exp_beat.last, final_result);
            errors++;
          end
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_sample(input logic signed [DATA_W-1:0] value, input logic last);
    beat_t b;
    b.value = value;
    b.last = last;
    sample_queue.push_back(b);
    samples_queued++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_block(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_sample(pick_value(), i + 1 == len);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic set_window(input int unsigned first, input int unsigned last);
    write_reg(REG_RANGE_FIRST, RANGE_W'(first));
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_A, RANGE_W'($urandom));
    write_reg(REG_RANGE_LAST, RANGE_W'(last));
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_B, RANGE_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Block is idle once all beats are in and all results are out; then a short settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (!(sample_queue.size() == 0 && !start && pending_results.size() == 0 && !busy));
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned first;
    int unsigned last;
    int unsigned len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_RANGE_FIRST;
    cfg_data = '0;
    samples_queued = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset window: single-value block, then a window past the end
    push_sample(32'sh7fff_ffff, 1'b1);
    push_sample(32'sh7fff_ffff, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(0, 1'b1);
    wait_drained();

    // inner window, spare indexes written too
    write_reg(REG_SPARE_A, 6'h3f);
    write_reg(REG_SPARE_B, 6'h2a);
    set_window(1, 4);
    push_sample(5, 1'b0);
    push_sample(32'sh7fff_ffff, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(0, 1'b0);
    push_sample(3, 1'b1);
    wait_drained();

    // empty window
    set_window(3, 2);
    push_sample(9, 1'b0);
    push_sample(-7, 1'b0);
    push_sample(4, 1'b0);
    push_sample(-2, 1'b0);
    push_sample(1, 1'b1);
    wait_drained();

    // whole short block, duplicates
    set_window(0, 4);
    push_sample(2, 1'b0);
    push_sample(-3, 1'b0);
    push_sample(2, 1'b0);
    push_sample(-3, 1'b0);
    push_sample(32'sh8000_0000, 1'b1);
    wait_drained();

    while (samples_queued < SAMPLE_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          // full depth and overflow
          set_window(0, 63);
          push_block(DEPTH + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6)));
        end
        1: begin
          first = ($urandom_range(0, 1) == 0) ? 63 : $urandom_range(0, 63);
          last = ($urandom_range(0, 1) == 0) ? 63 : $urandom_range(first, 63);
          set_window(first, last);
          push_block(DEPTH);
        end
        default: begin
          last = $urandom_range(0, 11);
          first = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, last);
          set_window(first, last);
          repeat ($urandom_range(2, 4)) begin
            len = $urandom_range(1, 14);
            push_block(len);
          end
        end
      endcase
      wait_drained();
    end

    repeat (150) @(negedge clk);
    $display("Covered %0d sample beats in %0d blocks; %0d result beats checked.",
             samples_queued, blocks_done, results_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== insertion_sort_range.f =====
rtl/isr_pkg.sv
rtl/isr_cell.sv
rtl/isr_ctrl.sv
rtl/insertion_sort_range.sv
dv/tb_insertion_sort_range.sv
